FILE: hw/rtl/diff_hunk_header_parser_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef DIFF_HUNK_HEADER_PARSER_MACROS_SVH
`define DIFF_HUNK_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, silenced during reset.
`define DHHP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dhhp check failed");

// Next-cycle implication, silenced during reset.
`define DHHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dhhp check failed");

`endif

FILE: hw/rtl/dhhp_pkg.sv
package dhhp_pkg;

   // Sizes
   localparam int LINE_BITS        = 24;
   localparam int MAX_HEADER_CHARS = 99;
   localparam int COUNT_BITS       = $clog2(MAX_HEADER_CHARS + 1);
   localparam int TEXT_BITS        = 8;
   localparam int OUT_BITS         = 25;
   localparam int KIND_BITS        = 2;
   localparam int RSP_DATA_BITS    = ((2 * OUT_BITS + 7) / 8) * 8;
   localparam int ACC_BITS         = LINE_BITS + 4;
   // Width of the zero-based line subtract, wide enough for a saturated count
   localparam int CALC_BITS        = (LINE_BITS + 1 > OUT_BITS) ? LINE_BITS + 1 : OUT_BITS;

   localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

   // Characters of the header grammar
   localparam logic [TEXT_BITS-1:0] CHAR_LF    = 8'h0a;
   localparam logic [TEXT_BITS-1:0] CHAR_CR    = 8'h0d;
   localparam logic [TEXT_BITS-1:0] CHAR_COMMA = 8'h2c;
   localparam logic [TEXT_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [TEXT_BITS-1:0] CHAR_NINE  = 8'h39;
   localparam logic [TEXT_BITS-1:0] CHAR_A     = 8'h61;
   localparam logic [TEXT_BITS-1:0] CHAR_C     = 8'h63;
   localparam logic [TEXT_BITS-1:0] CHAR_D     = 8'h64;

   typedef enum logic {
      OP_DATA  = 1'b0,
      OP_FLUSH = 1'b1
   } opcode_type;

   // Mode letter of the header
   typedef enum logic [1:0] {
      MODE_APPEND = 2'd0,
      MODE_CHANGE = 2'd1,
      MODE_DELETE = 2'd2
   } mode_type;

   // Mark kind of a result
   typedef enum logic [KIND_BITS-1:0] {
      KIND_APPEND = 2'd0,
      KIND_CHANGE = 2'd1,
      KIND_DELETE = 2'd2
   } kind_type;

   // Parsed header, handed from the parser to the mapper
   typedef struct packed {
      mode_type             mode;
      logic [LINE_BITS-1:0] old_start;
      logic [LINE_BITS-1:0] old_stop;
      logic                 old_has_end;
      logic [LINE_BITS-1:0] new_start;
      logic [LINE_BITS-1:0] new_stop;
      logic                 new_has_end;
   } hunk_type;

   // Decimal accumulate with saturation
   function automatic logic [LINE_BITS-1:0] acc_digit(input logic [LINE_BITS-1:0] acc,
                                                      input logic [3:0] digit);
      logic [ACC_BITS-1:0] wide;
      wide = (ACC_BITS'(acc) << 3) + (ACC_BITS'(acc) << 1) + ACC_BITS'(digit);
      return (wide > ACC_BITS'(LINE_MAX)) ? LINE_MAX : wide[LINE_BITS-1:0];
   endfunction

endpackage

FILE: hw/rtl/dhhp_parser.sv
module dhhp_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  dhhp_pkg::opcode_type               opcode,
   input  logic [dhhp_pkg::TEXT_BITS-1:0]     text_byte,
   output logic                               emit_now,
   output dhhp_pkg::hunk_type                 hunk
);

   typedef enum logic [2:0] {
      PH_S1   = 3'd0,
      PH_E1   = 3'd1,
      PH_S2   = 3'd2,
      PH_E2   = 3'd3,
      PH_FAIL = 3'd4
   } phase_type;

   logic                                at_line_start_ff, at_line_start_in;
   logic                                collecting_ff, collecting_in;
   logic [dhhp_pkg::COUNT_BITS-1:0]     char_count_ff, char_count_in;
   phase_type                           phase_ff, phase_in;
   dhhp_pkg::hunk_type                  hunk_ff, hunk_in;

   logic                                is_eol, is_digit, is_comma, is_mode;
   logic                                start_hdr, hdr_ok;
   dhhp_pkg::mode_type                  mode_hit;
   logic [3:0]                          digit;
   phase_type                           base_phase, parse_phase;
   dhhp_pkg::hunk_type                  base_hunk, parse_hunk;
   logic [dhhp_pkg::LINE_BITS-1:0]      acc_sel, acc_new;
   logic [dhhp_pkg::COUNT_BITS:0]       count_inc;

   // Classify the byte
   always_comb begin
      is_eol   = (text_byte == dhhp_pkg::CHAR_LF) || (text_byte == dhhp_pkg::CHAR_CR);
      is_digit = (text_byte >= dhhp_pkg::CHAR_ZERO) && (text_byte <= dhhp_pkg::CHAR_NINE);
      is_comma = (text_byte == dhhp_pkg::CHAR_COMMA);
      digit    = 4'(text_byte - dhhp_pkg::CHAR_ZERO);
      is_mode  = 1'b1;
      mode_hit = dhhp_pkg::MODE_APPEND;
      unique case (text_byte)
         dhhp_pkg::CHAR_A: mode_hit = dhhp_pkg::MODE_APPEND;
         dhhp_pkg::CHAR_C: mode_hit = dhhp_pkg::MODE_CHANGE;
         dhhp_pkg::CHAR_D: mode_hit = dhhp_pkg::MODE_DELETE;
         default:          is_mode  = 1'b0;
      endcase
   end

   // A digit at line start opens a fresh header
   assign start_hdr = at_line_start_ff && !is_eol && is_digit;
   assign hdr_ok    = collecting_ff && (char_count_ff != '0) &&
                      ((phase_ff == PH_S2) || (phase_ff == PH_E2));

   // Parse one character from the current or the fresh header
   always_comb begin
      base_phase = start_hdr ? PH_S1 : phase_ff;
      base_hunk  = start_hdr ? '0 : hunk_ff;

      case (base_phase)
         PH_S1:   acc_sel = base_hunk.old_start;
         PH_E1:   acc_sel = base_hunk.old_stop;
         PH_S2:   acc_sel = base_hunk.new_start;
         default: acc_sel = base_hunk.new_stop;
      endcase
      acc_new = dhhp_pkg::acc_digit(acc_sel, digit);

      parse_phase = base_phase;
      parse_hunk  = base_hunk;
      unique case (base_phase)
         PH_S1: begin
            if (is_comma) begin
               parse_phase = PH_E1;
               parse_hunk.old_has_end = 1'b1;
            end else if (is_mode) begin
               parse_phase = PH_S2;
               parse_hunk.mode = mode_hit;
            end else if (is_digit) begin
               parse_hunk.old_start = acc_new;
            end else begin
               parse_phase = PH_FAIL;
            end
         end
         PH_E1: begin
            if (is_mode) begin
               parse_phase = PH_S2;
               parse_hunk.mode = mode_hit;
            end else if (is_digit) begin
               parse_hunk.old_stop = acc_new;
            end else begin
               parse_phase = PH_FAIL;
            end
         end
         PH_S2: begin
            if (is_comma) begin
               parse_phase = PH_E2;
               parse_hunk.new_has_end = 1'b1;
            end else if (is_digit) begin
               parse_hunk.new_start = acc_new;
            end else begin
               parse_phase = PH_FAIL;
            end
         end
         PH_E2: begin
            if (is_digit) begin
               parse_hunk.new_stop = acc_new;
            end else begin
               parse_phase = PH_FAIL;
            end
         end
         default: parse_phase = PH_FAIL;
      endcase
   end

   // Next state for one beat
   always_comb begin
      at_line_start_in = at_line_start_ff;
      collecting_in    = collecting_ff;
      char_count_in    = char_count_ff;
      phase_in         = phase_ff;
      hunk_in          = hunk_ff;
      emit_now         = 1'b0;
      count_inc        = {1'b0, char_count_ff} + 1'b1;

      if ((opcode == dhhp_pkg::OP_FLUSH) || (!at_line_start_ff && is_eol)) begin
         // End of header: emit if valid, then drop the line
         emit_now         = hdr_ok;
         at_line_start_in = 1'b1;
         collecting_in    = 1'b0;
         char_count_in    = '0;
         phase_in         = PH_S1;
         hunk_in          = '0;
      end else if (at_line_start_ff) begin
         if (!is_eol) begin
            at_line_start_in = 1'b0;
         end
         if (start_hdr) begin
            collecting_in = 1'b1;
            char_count_in = dhhp_pkg::COUNT_BITS'(1);
            phase_in      = parse_phase;
            hunk_in       = parse_hunk;
         end
      end else if (collecting_ff) begin
         phase_in = parse_phase;
         hunk_in  = parse_hunk;
         // Abandon a header that grows too long
         if (count_inc >= (dhhp_pkg::COUNT_BITS + 1)'(dhhp_pkg::MAX_HEADER_CHARS)) begin
            collecting_in = 1'b0;
            char_count_in = '0;
         end else begin
            char_count_in = count_inc[dhhp_pkg::COUNT_BITS-1:0];
         end
      end
   end

   // Hold parser state, advance on each processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         at_line_start_ff <= 1'b1;
         collecting_ff    <= 1'b0;
         char_count_ff    <= '0;
         phase_ff         <= PH_S1;
         hunk_ff          <= '0;
      end else if (step) begin
         at_line_start_ff <= at_line_start_in;
         collecting_ff    <= collecting_in;
         char_count_ff    <= char_count_in;
         phase_ff         <= phase_in;
         hunk_ff          <= hunk_in;
      end
   end

   assign hunk = hunk_ff;

endmodule

FILE: hw/rtl/dhhp_mapper.sv
module dhhp_mapper (
   input  dhhp_pkg::hunk_type                  hunk,
   input  logic                                edited_is_new,
   output dhhp_pkg::kind_type                  mark_kind,
   output logic [dhhp_pkg::OUT_BITS-1:0]       first_line,
   output logic [dhhp_pkg::OUT_BITS-1:0]       last_line
);

   logic [dhhp_pkg::LINE_BITS-1:0] sel_start, sel_stop;
   logic                           minus_one;
   logic [dhhp_pkg::CALC_BITS-1:0] first_calc, last_calc;

   // Pick the side and the mark kind
   always_comb begin
      mark_kind = dhhp_pkg::KIND_APPEND;
      minus_one = 1'b1;
      if (edited_is_new) begin
         sel_start = hunk.new_start;
         sel_stop  = hunk.new_has_end ? hunk.new_stop : hunk.new_start;
         case (hunk.mode)
            dhhp_pkg::MODE_APPEND: mark_kind = dhhp_pkg::KIND_APPEND;
            dhhp_pkg::MODE_CHANGE: mark_kind = dhhp_pkg::KIND_CHANGE;
            default: begin
               mark_kind = dhhp_pkg::KIND_DELETE;
               minus_one = 1'b0;
            end
         endcase
      end else begin
         sel_start = hunk.old_start;
         sel_stop  = hunk.old_has_end ? hunk.old_stop : hunk.old_start;
         case (hunk.mode)
            dhhp_pkg::MODE_APPEND: begin
               mark_kind = dhhp_pkg::KIND_DELETE;
               minus_one = 1'b0;
            end
            dhhp_pkg::MODE_CHANGE: mark_kind = dhhp_pkg::KIND_CHANGE;
            default:               mark_kind = dhhp_pkg::KIND_APPEND;
         endcase
      end
   end

   // Convert to zero-based lines, except for delete marks; a zero start then gives minus one
   assign first_calc = dhhp_pkg::CALC_BITS'(sel_start) - dhhp_pkg::CALC_BITS'(minus_one);
   assign last_calc  = dhhp_pkg::CALC_BITS'(sel_stop) - dhhp_pkg::CALC_BITS'(minus_one);
   assign first_line = first_calc[dhhp_pkg::OUT_BITS-1:0];
   assign last_line  = last_calc[dhhp_pkg::OUT_BITS-1:0];

endmodule

FILE: hw/rtl/diff_hunk_header_parser.sv
// Channel  Dir  Beat fields
// req      in   tdata: text_byte[7:0]; tuser: opcode
// rsp      out  tdata: first_line[24:0], last_line[49:25]; tuser: mark_kind
// csr      in   csr_wdata: edited_is_new
//
// Each beat passes the input register, one parser update and the result register:
// its result loads once the result register is free, one beat per cycle while not stalled.
// The parser state register closes the only loop, one byte per cycle when not stalled.
// Reset is synchronous; it clears both stage valids, the parser and sets edited_is_new.
// A stalled result holds the input stage; a new beat is still taken while the
// input stage drains into a free result register.
`include "diff_hunk_header_parser_macros.svh"

module diff_hunk_header_parser (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [7:0]                             req_tdata,   // text_byte[7:0]
   input  logic [0:0]                             req_tuser,   // opcode[0]
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [dhhp_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,   // first_line, last_line
   output logic [dhhp_pkg::KIND_BITS-1:0]         rsp_tuser,   // mark_kind
   input  logic                                   csr_we,
   input  logic [0:0]                             csr_wdata    // edited_is_new
);

   logic                                   edited_is_new_ff;
   logic                                   in_valid_ff;
   dhhp_pkg::opcode_type                   in_opcode_ff;
   logic [dhhp_pkg::TEXT_BITS-1:0]         in_byte_ff;
   logic                                   rsp_valid_ff;
   dhhp_pkg::kind_type                     rsp_kind_ff;
   logic [dhhp_pkg::OUT_BITS-1:0]          rsp_first_ff, rsp_last_ff;

   logic                                   out_free, proc, emit_now;
   dhhp_pkg::hunk_type                     hunk;
   dhhp_pkg::kind_type                     map_kind;
   logic [dhhp_pkg::OUT_BITS-1:0]          map_first, map_last;

   // Handshake control
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign proc       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || proc;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         edited_is_new_ff <= 1'b1;
      end else if (csr_we) begin
         edited_is_new_ff <= csr_wdata[0];
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (proc) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_opcode_ff <= dhhp_pkg::opcode_type'(req_tuser[0]);
         in_byte_ff   <= req_tdata;
      end
   end

   dhhp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (proc),
      .opcode    (in_opcode_ff),
      .text_byte (in_byte_ff),
      .emit_now  (emit_now),
      .hunk      (hunk)
   );

   dhhp_mapper u_mapper (
      .hunk          (hunk),
      .edited_is_new (edited_is_new_ff),
      .mark_kind     (map_kind),
      .first_line    (map_first),
      .last_line     (map_last)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc && emit_now) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && emit_now) begin
         rsp_kind_ff  <= map_kind;
         rsp_first_ff <= map_first;
         rsp_last_ff  <= map_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {{(dhhp_pkg::RSP_DATA_BITS - 2 * dhhp_pkg::OUT_BITS){1'b0}},
                        rsp_last_ff, rsp_first_ff};

   // Checks
   `DHHP_ASSERT_NEXT(a_emit_loads, clock, reset, proc && emit_now, rsp_valid_ff)
   `DHHP_ASSERT_NEXT(a_in_holds, clock, reset, in_valid_ff && !proc,
                     in_valid_ff && $stable(in_byte_ff) && $stable(in_opcode_ff))
   `DHHP_ASSERT_NEXT(a_rsp_from_beat, clock, reset, !rsp_valid_ff,
                     !rsp_valid_ff || $past(proc))
   `DHHP_ASSERT_NOW(a_no_lost_result, clock, reset, rsp_valid_ff && !rsp_tready, !proc)

endmodule
